// ----- src/dmbc_pkg.sv -----
package dmbc_pkg;

  // Slot geometry
  localparam int unsigned SLOT_COUNT = 256;
  localparam int unsigned SLOT_W     = $clog2(SLOT_COUNT);
  localparam int unsigned OUT_SLOT_W = 8;

  // Field widths
  localparam int unsigned BB_W   = 17;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned PROD_W = SLOT_W + BB_W;

  // Queue between front and back
  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  // Remainder unit steps, one dividend bit per step
  localparam int unsigned DIV_CNT_W = $clog2(DATA_W);

  // Register reset values
  localparam logic [BB_W-1:0]   BLOCK_BYTES_RST = BB_W'(512);
  localparam logic [DATA_W-1:0] BUFFER_BASE_RST = '0;

  // Register index, taken from paddr[2]
  typedef enum logic {
    REG_BLOCK_BYTES = 1'b0,
    REG_BUFFER_BASE = 1'b1
  } reg_idx_e;

  typedef enum logic [1:0] {
    K_READ   = 2'd0,
    K_FILL   = 2'd1,
    K_WRITE  = 2'd2,
    K_WBLOCK = 2'd3
  } kind_e;

  typedef enum logic [3:0] {
    ST_HIT         = 4'd0,
    ST_MISS        = 4'd1,
    ST_PASS        = 4'd2,
    ST_FILLED      = 4'd3,
    ST_FILL_INVAL  = 4'd4,
    ST_WR_ACCEPT   = 4'd5,
    ST_WR_REJECT   = 4'd6,
    ST_BLK_UPDATED = 4'd7,
    ST_BLK_SKIPPED = 4'd8
  } status_e;

  // Classified request as it travels from front to back
  typedef struct packed {
    kind_e                    kind;
    logic [DATA_W-1:0]        block_number;
    logic signed [DATA_W-1:0] byte_count;
    logic [SLOT_W-1:0]        slot;
    logic                     neg;
    logic                     too_big;
  } dmbc_item_t;

  // Queue status seen by front and back
  typedef struct packed {
    logic full;
    logic empty;
  } dmbc_qstat_t;

endpackage

// ----- src/dmbc_front.sv -----
module dmbc_front import dmbc_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [1:0]               kind_i,
  input  logic [DATA_W-1:0]        block_number_i,
  input  logic signed [DATA_W-1:0] byte_count_i,
  input  logic [BB_W-1:0]          block_bytes_i,
  input  dmbc_qstat_t              qstat_i,
  output logic                     busy_o,
  output logic                     push_o,
  output dmbc_item_t               item_o
);

  logic       valid_d, valid_q;
  dmbc_item_t item_d, item_q;
  logic       accept;

  // Hand the held request to the queue when it has room
  assign push_o = valid_q & ~qstat_i.full;
  assign busy_o = valid_q & qstat_i.full;
  assign accept = start_i & ~busy_o;
  assign item_o = item_q;

  // Classify the incoming request
  always_comb begin
    item_d.kind         = kind_e'(kind_i);
    item_d.block_number = block_number_i;
    item_d.byte_count   = byte_count_i;
    item_d.slot         = block_number_i[SLOT_W-1:0];
    item_d.neg          = byte_count_i[DATA_W-1];
    item_d.too_big      = $unsigned(byte_count_i) > DATA_W'(block_bytes_i);
  end

  assign valid_d = accept | (valid_q & ~push_o);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Capture the request payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= item_d;
    end
  end

endmodule

// ----- src/dmbc_queue.sv -----
module dmbc_queue import dmbc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  dmbc_item_t  item_i,
  input  logic        pop_i,
  output dmbc_item_t  item_o,
  output dmbc_qstat_t qstat_o
);

  dmbc_item_t        mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_d, wr_ptr_q;
  logic [QPTR_W-1:0] rd_ptr_d, rd_ptr_q;
  logic [QCNT_W-1:0] cnt_d, cnt_q;

  assign qstat_o.full  = (cnt_q == QCNT_W'(QDEPTH));
  assign qstat_o.empty = (cnt_q == '0);
  assign item_o        = mem_q[rd_ptr_q];

  // Advance pointers with wrap at the queue depth
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Store the pushed request
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

// ----- src/dmbc_back.sv -----
module dmbc_back import dmbc_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  dmbc_item_t               item_i,
  input  dmbc_qstat_t              qstat_i,
  input  logic [BB_W-1:0]          block_bytes_i,
  input  logic [DATA_W-1:0]        buffer_base_i,
  output logic                     pop_o,
  output logic                     done_o,
  output status_e                  status_o,
  output logic [SLOT_W-1:0]        slot_o,
  output logic [DATA_W-1:0]        data_address_o,
  output logic signed [DATA_W-1:0] returned_bytes_o
);

  typedef enum logic [2:0] {
    B_IDLE = 3'b001,
    B_LOOK = 3'b010,
    B_DIV  = 3'b100
  } back_state_e;

  back_state_e state_d, state_q;
  dmbc_item_t  item_q;

  // Tag store and valid bits
  logic [DATA_W-1:0] tag_mem_q [SLOT_COUNT];
  logic [SLOT_COUNT-1:0] slot_valid_q;
  logic [DATA_W-1:0] tag_rd_q;
  logic              valid_rd_q;
  logic [PROD_W-1:0] prod_q;

  // Remainder unit
  logic [BB_W-1:0]      rem_d, rem_q;
  logic [DATA_W-1:0]    dvd_d, dvd_q;
  logic [DIV_CNT_W-1:0] cnt_d, cnt_q;
  logic [BB_W:0]        trial;
  logic [BB_W:0]        trial_sub;

  // Result registers
  logic                     done_d, done_q;
  status_e                  status_d, status_q;
  logic [SLOT_W-1:0]        slot_d, slot_q;
  logic [DATA_W-1:0]        addr_d, addr_q;
  logic signed [DATA_W-1:0] ret_d, ret_q;

  logic hit;
  logic fill_ok;
  logic tag_we;
  logic valid_set;
  logic valid_clr;

  assign pop_o = (state_q == B_IDLE) && !qstat_i.empty;
  assign hit   = valid_rd_q && (tag_rd_q == item_q.block_number);
  assign fill_ok = !item_q.neg && ($unsigned(item_q.byte_count) == DATA_W'(block_bytes_i));

  // One restoring remainder step
  assign trial     = {rem_q, dvd_q[DATA_W-1]};
  assign trial_sub = trial - {1'b0, block_bytes_i};

  always_comb begin
    state_d   = state_q;
    rem_d     = rem_q;
    dvd_d     = dvd_q;
    cnt_d     = cnt_q;
    done_d    = 1'b0;
    status_d  = status_q;
    slot_d    = slot_q;
    addr_d    = addr_q;
    ret_d     = ret_q;
    tag_we    = 1'b0;
    valid_set = 1'b0;
    valid_clr = 1'b0;
    unique case (state_q)
      B_IDLE: begin
        if (pop_o) begin
          state_d = B_LOOK;
        end
      end
      B_LOOK: begin
        slot_d  = item_q.slot;
        addr_d  = buffer_base_i + DATA_W'(prod_q);
        ret_d   = item_q.byte_count;
        state_d = B_IDLE;
        done_d  = 1'b1;
        unique case (item_q.kind)
          K_READ: begin
            if (item_q.neg || item_q.too_big) begin
              status_d = ST_PASS;
            end else if (hit) begin
              status_d = ST_HIT;
            end else begin
              status_d = ST_MISS;
            end
          end
          K_FILL: begin
            if (fill_ok) begin
              status_d  = ST_FILLED;
              tag_we    = 1'b1;
              valid_set = 1'b1;
            end else begin
              status_d  = ST_FILL_INVAL;
              valid_clr = 1'b1;
            end
          end
          K_WRITE: begin
            if (item_q.neg) begin
              status_d = ST_WR_REJECT;
              ret_d    = '1;
            end else if (block_bytes_i == '0) begin
              if (item_q.byte_count == '0) begin
                status_d = ST_WR_ACCEPT;
              end else begin
                status_d = ST_WR_REJECT;
                ret_d    = '1;
              end
            end else begin
              // Check for a whole number of blocks bit by bit
              done_d  = 1'b0;
              state_d = B_DIV;
              rem_d   = '0;
              dvd_d   = item_q.byte_count;
              cnt_d   = DIV_CNT_W'(DATA_W - 1);
            end
          end
          K_WBLOCK: begin
            if (hit) begin
              status_d = ST_BLK_UPDATED;
              ret_d    = DATA_W'(block_bytes_i);
            end else begin
              status_d = ST_BLK_SKIPPED;
              ret_d    = '0;
            end
          end
          default: begin
            status_d = ST_BLK_SKIPPED;
          end
        endcase
      end
      B_DIV: begin
        rem_d = trial_sub[BB_W] ? trial[BB_W-1:0] : trial_sub[BB_W-1:0];
        dvd_d = {dvd_q[DATA_W-2:0], 1'b0};
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          state_d = B_IDLE;
          done_d  = 1'b1;
          if (rem_d == '0) begin
            status_d = ST_WR_ACCEPT;
          end else begin
            status_d = ST_WR_REJECT;
            ret_d    = '1;
          end
        end
      end
      default: begin
        state_d = B_IDLE;
      end
    endcase
  end

  // Control state and valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= B_IDLE;
      done_q       <= 1'b0;
      slot_valid_q <= '0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
      if (valid_set) begin
        slot_valid_q[item_q.slot] <= 1'b1;
      end else if (valid_clr) begin
        slot_valid_q[item_q.slot] <= 1'b0;
      end
    end
  end

  // Tag store: read at pop, written by a good fill
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      tag_rd_q <= tag_mem_q[item_i.slot];
    end
    if (tag_we) begin
      tag_mem_q[item_q.slot] <= item_q.block_number;
    end
  end

  // Load the working request and the slot offset
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      item_q     <= item_i;
      valid_rd_q <= slot_valid_q[item_i.slot];
      prod_q     <= PROD_W'(item_i.slot) * PROD_W'(block_bytes_i);
    end
    rem_q    <= rem_d;
    dvd_q    <= dvd_d;
    cnt_q    <= cnt_d;
    status_q <= status_d;
    slot_q   <= slot_d;
    addr_q   <= addr_d;
    ret_q    <= ret_d;
  end

  assign done_o           = done_q;
  assign status_o         = status_q;
  assign slot_o           = slot_q;
  assign data_address_o   = addr_q;
  assign returned_bytes_o = ret_q;

endmodule

// ----- src/direct_mapped_block_cache_tags.sv -----
// Tag and control logic of a direct-mapped, write-through block cache.
// Request channel: drive kind_i, block_number_i and byte_count_i with start;
// the request is taken at a clock edge where start is high and busy is low.
// Result channel: done_o is high for one cycle with status_o, slot_o,
// data_address_o and returned_bytes_o; the receiver takes it in that cycle
// and cannot hold it off.
// A front stage classifies each request and hands it to a two-entry queue;
// a back sequencer reads the tag store, forms the buffer address and
// answers. The back end takes a new request only after it has answered
// the last one. For a write request of non-negative size with a nonzero
// block size, its whole-block check runs a remainder unit one dividend
// bit per cycle.
// busy rises only when the front stage holds a request and the queue is full.
// Configuration (APB): block_bytes at address 0, buffer_base at address 4;
// write only while no request is in flight.
// Reset empties every slot, clears the queue and loads block_bytes = 512
// and buffer_base = 0.
module direct_mapped_block_cache_tags import dmbc_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start,
  output logic                     busy,
  input  logic [1:0]               kind_i,
  input  logic [DATA_W-1:0]        block_number_i,
  input  logic signed [DATA_W-1:0] byte_count_i,
  output logic                     done_o,
  output logic [3:0]               status_o,
  output logic [OUT_SLOT_W-1:0]    slot_o,
  output logic [DATA_W-1:0]        data_address_o,
  output logic signed [DATA_W-1:0] returned_bytes_o,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [2:0]               paddr,
  input  logic [DATA_W-1:0]        pwdata,
  output logic [DATA_W-1:0]        prdata,
  output logic                     pready
);

  logic [BB_W-1:0]   block_bytes_q;
  logic [DATA_W-1:0] buffer_base_q;
  logic              cfg_we;
  reg_idx_e          cfg_idx;

  logic        q_push;
  logic        q_pop;
  dmbc_item_t  front_item;
  dmbc_item_t  q_item;
  dmbc_qstat_t q_stat;
  status_e     status;
  logic [SLOT_W-1:0] slot;

  // Register access
  assign pready  = 1'b1;
  assign cfg_idx = reg_idx_e'(paddr[2]);
  assign cfg_we  = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      block_bytes_q <= BLOCK_BYTES_RST;
      buffer_base_q <= BUFFER_BASE_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_BLOCK_BYTES: block_bytes_q <= pwdata[BB_W-1:0];
        REG_BUFFER_BASE: buffer_base_q <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_BLOCK_BYTES: prdata = DATA_W'(block_bytes_q);
      REG_BUFFER_BASE: prdata = buffer_base_q;
      default:         prdata = '0;
    endcase
  end

  dmbc_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start),
    .kind_i         (kind_i),
    .block_number_i (block_number_i),
    .byte_count_i   (byte_count_i),
    .block_bytes_i  (block_bytes_q),
    .qstat_i        (q_stat),
    .busy_o         (busy),
    .push_o         (q_push),
    .item_o         (front_item)
  );

  dmbc_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .item_i  (front_item),
    .pop_i   (q_pop),
    .item_o  (q_item),
    .qstat_o (q_stat)
  );

  dmbc_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .item_i           (q_item),
    .qstat_i          (q_stat),
    .block_bytes_i    (block_bytes_q),
    .buffer_base_i    (buffer_base_q),
    .pop_o            (q_pop),
    .done_o           (done_o),
    .status_o         (status),
    .slot_o           (slot),
    .data_address_o   (data_address_o),
    .returned_bytes_o (returned_bytes_o)
  );

  assign status_o = status;
  assign slot_o   = OUT_SLOT_W'(slot);

`ifndef SYNTHESIS
  // The front never pushes into a full queue
  assert property (@(posedge clk_i) disable iff (!rst_ni) q_push |-> !q_stat.full)
    else $error("push into full queue");

  // The back never pops an empty queue
  assert property (@(posedge clk_i) disable iff (!rst_ni) q_pop |-> !q_stat.empty)
    else $error("pop from empty queue");

  // Result strobes never come back to back
  assert property (@(posedge clk_i) disable iff (!rst_ni) done_o |=> !done_o)
    else $error("back-to-back result strobes");

  // A result carries a defined status code
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (status_o <= ST_BLK_SKIPPED))
    else $error("undefined status code");
`endif

endmodule
